FILE: hw/rtl/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg: shared constants and types for the sprite slot cache
// Slot count, field widths, opcodes and the records that pass along the cell
// chain.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int SLOTS          = 8;
  localparam int TILES_PER_SLOT = 64;
  localparam int START_TILE     = 512;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W   = 12;
  localparam int TIME_W  = 32;
  localparam int AGE_W   = 16;
  localparam int FREED_W = 8;
  localparam int TILE_W  = 10;
  localparam int OUT_SLOT_W = 3;

  localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd500;

  localparam logic OP_SWEEP   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // search record handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [TIME_W-1:0] best_age;
    logic [SLOT_W-1:0] best_idx;
    logic [FREED_W-1:0] freed;
  } scan_t;

  // slot write broadcast at the end of a request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } slot_wr_t;

  function automatic logic [TILE_W-1:0] tile_of(input logic [SLOT_W-1:0] slot);
    tile_of = TILE_W'(START_TILE + TILES_PER_SLOT * int'(slot));
  endfunction

endpackage

FILE: hw/rtl/ssc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_cell: one cache slot of the sprite slot cache
// Holds key, valid and last-seen time; folds its slot into the passing search
// record and frees itself on an expired sweep.
// ----------------------------------------------------------------------------
module ssc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ssc_pkg::SLOT_W-1:0]    cell_idx,
  input  ssc_pkg::scan_t                scan_in,
  input  logic                          op,
  input  logic [ssc_pkg::KEY_W-1:0]     key,
  input  logic [ssc_pkg::TIME_W-1:0]    now,
  input  logic [ssc_pkg::AGE_W-1:0]     age_limit,
  input  ssc_pkg::slot_wr_t             wr,
  output ssc_pkg::scan_t                scan_out,
  output logic                          valid_o
);
  import ssc_pkg::*;

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0] seen_r, seen_nxt;
  scan_t             scan_r, scan_nxt;

  logic [TIME_W-1:0] age;
  logic              match;
  logic              expired;

  assign age     = now - seen_r;
  assign match   = valid_r && (key_r == key);
  assign expired = valid_r && (age >= {{(TIME_W-AGE_W){1'b0}}, age_limit});

  always_comb begin
    scan_nxt = scan_in;
    if (op == OP_SWEEP) begin
      if (expired && (int'(cell_idx) < FREED_W)) begin
        scan_nxt.freed = scan_in.freed | (FREED_W'(1) << cell_idx);
      end
    end else begin
      if (match && !scan_in.hit) begin
        scan_nxt.hit     = 1'b1;
        scan_nxt.hit_idx = cell_idx;
      end
      if (!valid_r && !scan_in.free_found) begin
        scan_nxt.free_found = 1'b1;
        scan_nxt.free_idx   = cell_idx;
      end
      // strictly older wins, so ties stay with the lower slot
      if (age > scan_in.best_age) begin
        scan_nxt.best_age = age;
        scan_nxt.best_idx = cell_idx;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    seen_nxt  = seen_r;
    if (scan_in.active && (op == OP_SWEEP) && expired) begin
      valid_nxt = 1'b0;
    end
    if (wr.en && (wr.idx == cell_idx)) begin
      valid_nxt = 1'b1;
      key_nxt   = wr.key;
      seen_nxt  = wr.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      scan_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      scan_r  <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    seen_r <= seen_nxt;
  end

  assign scan_out = scan_r;
  assign valid_o  = valid_r;

endmodule

FILE: hw/rtl/sprite_slot_cache_timestamp_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_slot_cache_timestamp_lru: sprite key to tile slot cache
// Fully associative slot cache with oldest-first replacement and age sweep,
// built as a chain of slot cells that a search record walks through.
// ----------------------------------------------------------------------------
// The search record passes start_r, then the scan register of each cell of the
//   chain in turn, then fin_r; the chosen slot is then updated and the output
//   loaded once the output register is free or its word is being taken.
// A new word is taken only when idle, once the last result has been loaded.
// Reset (rst_n low, synchronous): all slots invalid, chain and output empty,
//   age limit back to 500 ms.
module sprite_slot_cache_timestamp_lru (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [3:0] sprite_type, [11:4] frame_index,
                                  // [43:12] now_ms, [47:44] zero
  input  logic        in_tuser,   // [0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] slot_index, [12:3] tile_base,
                                  // [13] hit, [14] load_needed,
                                  // [15] evicted, [23:16] freed_mask
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data // age_limit_ms
);
  import ssc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              start_r;
  logic [AGE_W-1:0]  age_limit_r;

  // request held for the whole walk
  logic              req_op_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [TIME_W-1:0] req_now_r;

  scan_t             scan_c [0:SLOTS];
  scan_t             fin_r;
  logic [SLOTS-1:0]  valid_vec;
  logic [SLOTS:0]    active_vec;
  slot_wr_t          wr;

  logic              in_acc;
  logic              ld;
  logic [SLOT_W-1:0] pick;
  logic              pick_evict;

  logic              out_tvalid_r;
  logic [23:0]       out_tdata_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= AGE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      age_limit_r <= cfg_wr_data;
    end
  end

  // search record entering cell 0: empty, best age zero at slot 0
  always_comb begin
    scan_c[0]        = '0;
    scan_c[0].active = start_r;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ssc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (SLOT_W'(i)),
      .scan_in   (scan_c[i]),
      .op        (req_op_r),
      .key       (req_key_r),
      .now       (req_now_r),
      .age_limit (age_limit_r),
      .wr        (wr),
      .scan_out  (scan_c[i+1]),
      .valid_o   (valid_vec[i])
    );
  end

  for (genvar i = 0; i <= SLOTS; i++) begin : g_act
    assign active_vec[i] = scan_c[i].active;
  end

  // hit first, then lowest free slot, else the oldest
  always_comb begin
    pick_evict = 1'b0;
    priority if (fin_r.hit) begin
      pick = fin_r.hit_idx;
    end else if (fin_r.free_found) begin
      pick = fin_r.free_idx;
    end else begin
      pick       = fin_r.best_idx;
      pick_evict = 1'b1;
    end
  end

  assign ld = (state_r == ST_WAIT) && (!out_tvalid_r || out_tready);

  always_comb begin
    wr.en    = ld && (req_op_r == OP_REQUEST);
    wr.idx   = pick;
    wr.key   = req_key_r;
    wr.stamp = req_now_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_c[SLOTS].active) state_nxt = ST_WAIT;
      ST_WAIT: if (ld) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      start_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc;
      if (ld) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op_r  <= in_tuser;
      req_key_r <= {in_tdata[3:0], in_tdata[11:4]};
      req_now_r <= in_tdata[43:12];
    end
    if ((state_r == ST_SCAN) && scan_c[SLOTS].active) begin
      fin_r <= scan_c[SLOTS];
    end
    if (ld) begin
      if (req_op_r == OP_SWEEP) begin
        out_tdata_r <= {fin_r.freed, 1'b0, 1'b0, 1'b0,
                        tile_of(SLOT_W'(0)), OUT_SLOT_W'(0)};
      end else begin
        out_tdata_r <= {FREED_W'(0), pick_evict, !fin_r.hit, fin_r.hit,
                        tile_of(pick), OUT_SLOT_W'(pick)};
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  // only one search record in the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(active_vec))
    else $error("more than one search in the cell chain");

  // a request leaves its slot valid
  a_wr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> valid_vec[$past(wr.idx)])
    else $error("written slot not valid");

  // eviction only when every slot is occupied
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && pick_evict) |-> (&valid_vec))
    else $error("eviction with a free slot");

  // a result is loaded only when the output is free or draining
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tdata_r == $past(out_tdata_r)))
    else $error("stalled result overwritten");
`endif

endmodule

FILE: tb/tb_sprite_slot_cache_timestamp_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_slot_cache_timestamp_lru: self-checking bench for the slot cache
// Drives request and sweep words into the cache and mirrors the slot table
// in a behavioural model. Each result word is checked field by field against
// the oldest pending prediction. A directed part covers fill, hit, eviction
// order, age ties, timestamp wrap and the age limit extremes. Random phases
// then run at several age limits, all but one with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_sprite_slot_cache_timestamp_lru;
  import ssc_pkg::*;

  // run limit: far above what all the words with their gaps and stalls need
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int POOL_KEYS   = 12;

  // one result word, laid out exactly as out_tdata (slot in the low bits)
  typedef struct packed {
    logic [FREED_W-1:0]    freed;
    logic                  evicted;
    logic                  load;
    logic                  hit;
    logic [TILE_W-1:0]     tile;
    logic [OUT_SLOT_W-1:0] slot;
  } cache_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;  // [3:0] sprite_type, [11:4] frame_index,
                                  // [43:12] now_ms, [47:44] zero
  logic        in_tuser    = 1'b0;  // [0] op
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;         // [2:0] slot_index, [12:3] tile_base,
                                  // [13] hit, [14] load_needed,
                                  // [15] evicted, [23:16] freed_mask
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;  // age_limit_ms

  sprite_slot_cache_timestamp_lru dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Slot table mirror and result predictor
  // --------------------------------------------------------------------------
  logic              line_valid [SLOTS];
  logic [KEY_W-1:0]  line_key   [SLOTS];
  logic [TIME_W-1:0] line_stamp [SLOTS];
  logic [AGE_W-1:0]  age_limit;

  cache_result_t pending_results[$];

  int error_count  = 0;
  int cycle_count  = 0;
  int n_requests   = 0;
  int n_hits       = 0;
  int n_evictions  = 0;
  int n_sweeps     = 0;
  int n_freed      = 0;
  bit stall_en     = 1'b1;  // random gaps on both streams when set

  function automatic void clear_line(int s);
    line_valid[s] = 1'b0;
    line_key[s]   = '0;
    line_stamp[s] = '0;
  endfunction

  // Work out the result of one word and update the mirrored slot table.
  function automatic cache_result_t predict_slot(logic op, logic [KEY_W-1:0] key,
                                                 logic [TIME_W-1:0] now);
    cache_result_t     r;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] oldest_age;
    bit                found;
    int                pick;
    r     = '0;
    found = 1'b0;
    pick  = 0;
    if (op == OP_SWEEP) begin
      n_sweeps++;
      for (int i = 0; i < SLOTS; i++) begin
        age = now - line_stamp[i];
        if (line_valid[i] && age >= TIME_W'(age_limit)) begin
          clear_line(i);
          n_freed++;
          if (i < FREED_W) r.freed[i] = 1'b1;
        end
      end
      r.tile = TILE_W'(START_TILE);
      return r;
    end
    n_requests++;
    // hit search
    for (int i = 0; i < SLOTS && !found; i++) begin
      if (line_valid[i] && line_key[i] == key) begin
        found = 1'b1;
        pick  = i;
        r.hit = 1'b1;
      end
    end
    // lowest free slot
    for (int i = 0; i < SLOTS && !found; i++) begin
      if (!line_valid[i]) begin
        found = 1'b1;
        pick  = i;
      end
    end
    // full: oldest slot wins, ties stay with the lower index
    if (!found) begin
      oldest_age = now - line_stamp[0];
      for (int i = 1; i < SLOTS; i++) begin
        age = now - line_stamp[i];
        if (age > oldest_age) begin
          oldest_age = age;
          pick       = i;
        end
      end
      r.evicted = 1'b1;
      n_evictions++;
    end
    if (r.hit) n_hits++;
    line_valid[pick] = 1'b1;
    line_key[pick]   = key;
    line_stamp[pick] = now;
    r.slot = OUT_SLOT_W'(pick);
    r.tile = TILE_W'(START_TILE + TILES_PER_SLOT * pick);
    r.load = !r.hit;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers; all called at a falling edge and return at one
  // --------------------------------------------------------------------------

  // Offer one word; predict its result once the handshake has taken it.
  task automatic send_word(input logic op, input logic [KEY_W-1:0] key,
                           input logic [TIME_W-1:0] now);
    while (stall_en && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, now, key[7:0], key[11:8]};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_slot(op, key, now));
    @(negedge clk);
  endtask

  // Stop offering, wait for every pending result, then let the pipe settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SLOTS + 4) @(negedge clk);
  endtask

  // Age limit write, only ever with the cache idle.
  task automatic set_age_limit(input logic [AGE_W-1:0] limit);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    age_limit = limit;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fill from empty, a hit, eviction of the oldest, timestamp wrap, and a
  // sweep against the reset age limit with ages either side of it.
  task automatic test_fill_hit_evict();
    send_word(OP_SWEEP,   12'h000, 32'h0000_0000);  // sweep of an empty cache
    send_word(OP_REQUEST, 12'h000, 32'h0000_0001);  // sprite type 0 is a key
    send_word(OP_REQUEST, 12'hFFF, 32'h0000_0002);
    send_word(OP_REQUEST, 12'h000, 32'h0000_0003);  // hit, restamped
    for (int k = 2; k < SLOTS; k++)
      send_word(OP_REQUEST, KEY_W'(12'h100 + k), TIME_W'(10 + k - 2));
    send_word(OP_REQUEST, 12'h555, 32'h0000_0014);  // full: oldest is slot 1
    send_word(OP_REQUEST, 12'h0F0, 32'hFFFF_FFFF);  // top of the time range
    // wrapped ages; slot stamped at 12 sits exactly on the 500 ms limit
    send_word(OP_SWEEP,   12'hA5A, 32'h0000_0200);
  endtask

  // Age limit at zero, all-equal ages on eviction, and the limit at 65535
  // and at 1 with ages just under and on the limit.
  task automatic test_age_limit_extremes();
    set_age_limit('0);
    send_word(OP_SWEEP, 12'h000, 32'd600);          // everything valid goes
    for (int k = 0; k < SLOTS; k++)
      send_word(OP_REQUEST, KEY_W'(12'h3C0 + k), 32'd700);
    send_word(OP_REQUEST, 12'hF0F, 32'd700);        // all ages zero: slot 0
    set_age_limit(16'hFFFF);
    send_word(OP_SWEEP, 12'h000, 32'd700 + 32'd65534);
    send_word(OP_SWEEP, 12'h000, 32'd700 + 32'd65535);
    set_age_limit(16'd1);
    send_word(OP_REQUEST, 12'h0AB, 32'd5);
    send_word(OP_SWEEP,   12'h000, 32'd5);
    send_word(OP_SWEEP,   12'h000, 32'd6);
  endtask

  // Mostly well-formed traffic: a small key pool on a clock that moves on
  // by up to a quarter of the limit plus two per word, so hits, evictions and sweeps
  // all happen. About one word in ten is noise with a random key and time.
  task automatic test_random_traffic(input int n_words, input logic [AGE_W-1:0] limit,
                                     input bit calm);
    logic [KEY_W-1:0]  key_pool [POOL_KEYS];
    logic [TIME_W-1:0] clock_ms;
    logic [KEY_W-1:0]  key;
    int                roll;
    set_age_limit(limit);
    stall_en = !calm;
    for (int k = 0; k < POOL_KEYS; k++) key_pool[k] = KEY_W'($urandom);
    clock_ms = $urandom;
    for (int n = 0; n < n_words; n++) begin
      roll     = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(limit / 4 + 2);
      key      = key_pool[$urandom_range(POOL_KEYS - 1)];
      if (roll < 15)
        send_word(OP_SWEEP, KEY_W'($urandom), clock_ms);
      else if (roll < 90)
        send_word(OP_REQUEST, key, clock_ms);
      else
        send_word(logic'($urandom_range(1)), KEY_W'($urandom), TIME_W'($urandom));
    end
    stall_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, field-by-field check
  // --------------------------------------------------------------------------
  always @(negedge clk)
    out_tready <= !stall_en || ($urandom_range(99) >= 37);

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_results
    cache_result_t got;
    cache_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result word 0x%06h with nothing pending", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.slot !== want.slot || got.tile !== want.tile ||
            got.hit !== want.hit || got.load !== want.load ||
            got.evicted !== want.evicted || got.freed !== want.freed)
          flag_error($sformatf({"slot %0d/%0d tile %0d/%0d hit %b/%b load %b/%b ",
                                "evicted %b/%b freed %02h/%02h (expected/actual)"},
                               want.slot, got.slot, want.tile, got.tile,
                               want.hit, got.hit, want.load, got.load,
                               want.evicted, got.evicted, want.freed, got.freed));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("sprite_slot_cache_timestamp_lru test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < SLOTS; i++) clear_line(i);
    age_limit = AGE_LIMIT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_hit_evict();
    test_age_limit_extremes();
    test_random_traffic(300, AGE_LIMIT_RESET, 1'b0);
    test_random_traffic(300, 16'd1, 1'b0);
    test_random_traffic(300, 16'hFFFF, 1'b0);
    test_random_traffic(300, AGE_W'($urandom_range(2, 3000)), 1'b1);  // no gaps
    test_random_traffic(300, AGE_W'($urandom_range(50, 900)), 1'b0);
    wait_drained();

    $display("Ran %0d requests (%0d hits, %0d evictions) and %0d sweeps freeing %0d slots",
             n_requests, n_hits, n_evictions, n_sweeps, n_freed);
    $display("Age limits 0, 1, 500, 65535 and random; one phase without stream gaps");
    if (error_count == 0) begin
      $display("sprite_slot_cache_timestamp_lru test passed");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("sprite_slot_cache_timestamp_lru test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_cell.sv
hw/rtl/sprite_slot_cache_timestamp_lru.sv
tb/tb_sprite_slot_cache_timestamp_lru.sv
